### hw/rtl/string_literal_escape_decoder_top_assert.svh
// Assertion macros for the string literal escape decoder
`ifndef STRING_LITERAL_ESCAPE_DECODER_TOP_ASSERT_SVH
`define STRING_LITERAL_ESCAPE_DECODER_TOP_ASSERT_SVH

// Checked property, ignored while reset is held
`define SLED_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sled assertion failed");

// Checked property, also during reset
`define SLED_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sled assertion failed during or after reset");

`endif

### hw/rtl/sled_pkg.sv
// Types, codes and helpers for the string literal escape decoder
package sled_pkg;

    localparam logic [2:0] M_PLAIN = 3'd0;
    localparam logic [2:0] M_ESC   = 3'd1;
    localparam logic [2:0] M_OCT   = 3'd2;
    localparam logic [2:0] M_HEX1  = 3'd3;
    localparam logic [2:0] M_HEX2  = 3'd4;

    localparam logic [1:0] K_BYTE   = 2'd0;
    localparam logic [1:0] K_CLOSED = 2'd1;
    localparam logic [1:0] K_UNTERM = 2'd2;

    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_BSLASH = 8'h5c;
    localparam logic [7:0] C_DIG0   = 8'h30;
    localparam logic [7:0] C_DIG3   = 8'h33;
    localparam logic [7:0] C_DIG4   = 8'h34;
    localparam logic [7:0] C_DIG7   = 8'h37;
    localparam logic [7:0] C_DIG9   = 8'h39;
    localparam logic [7:0] C_LC_A   = 8'h61;
    localparam logic [7:0] C_LC_F   = 8'h66;
    localparam logic [7:0] C_UC_A   = 8'h41;
    localparam logic [7:0] C_UC_F   = 8'h46;
    localparam logic [7:0] C_LC_N   = 8'h6e;
    localparam logic [7:0] C_LC_R   = 8'h72;
    localparam logic [7:0] C_LC_T   = 8'h74;
    localparam logic [7:0] C_LC_X   = 8'h78;
    localparam logic [7:0] C_LF     = 8'h0a;
    localparam logic [7:0] C_CR     = 8'h0d;
    localparam logic [7:0] C_TAB    = 8'h09;

    localparam int unsigned MAX_RES = 4;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] oct_val;
        logic [1:0] oct_left;
        logic [7:0] hex_held;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } t_res;

    localparam t_state C_STATE_CLEAR = '{mode: M_PLAIN, oct_val: 8'd0,
                                         oct_left: 2'd0, hex_held: 8'd0};

    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = (c inside {[C_DIG0:C_DIG9], [C_LC_A:C_LC_F], [C_UC_A:C_UC_F]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[C_DIG0:C_DIG9]}) begin
            v = c - C_DIG0;
        end else if (c inside {[C_LC_A:C_LC_F]}) begin
            v = c - C_LC_A + 8'd10;
        end else begin
            v = c - C_UC_A + 8'd10;
        end
        hex_val = v[3:0];
    endfunction

endpackage

### hw/rtl/string_literal_escape_decoder_top.sv
// Top level of the string literal escape decoder
// One source byte is taken per transaction and decoded combinationally into up
// to four results (decoded bytes, string closed or unterminated), held in a
// result register and handed out one per cycle while i_ready is high, the last
// flagged by o_last. A byte yielding at most one result is taken every cycle
// while i_ready is high; one yielding more holds the result register until all
// are delivered, and the next byte is taken in the cycle its last one goes out.
// Bytes that yield nothing (backslash, escape digits) keep o_ready high.
module string_literal_escape_decoder_top
    import sled_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_source,
    input  logic [7:0] i_quote_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);

    t_state             r_state;
    t_state             n_state;
    t_res [MAX_RES-1:0] r_res;
    t_res [MAX_RES-1:0] n_res;
    logic [2:0]         n_cnt;
    logic [2:0]         r_left;
    logic [1:0]         r_idx;
    logic               in_acc;
    logic               out_acc;

    sled_step u_step (
        .i_ch            (i_ch),
        .i_end_of_source (i_end_of_source),
        .i_quote_char    (i_quote_char),
        .i_state         (r_state),
        .o_state         (n_state),
        .o_res           (n_res),
        .o_cnt           (n_cnt)
    );

    assign o_valid = (r_left != 3'd0);
    assign o_last  = (r_left == 3'd1);
    assign o_ready = (r_left == 3'd0) || (r_left == 3'd1 && i_ready);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    assign o_out_byte = r_res[r_idx].data;
    assign o_kind     = r_res[r_idx].kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_STATE_CLEAR;
            r_left  <= 3'd0;
            r_idx   <= 2'd0;
        end else if (in_acc) begin
            r_state <= n_state;
            r_left  <= n_cnt;
            r_idx   <= 2'd0;
        end else if (out_acc) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

endmodule

### hw/rtl/sled_step.sv
// One decode step: results and next state for one source byte
module sled_step
    import sled_pkg::*;
(
    input  logic [7:0]           i_ch,
    input  logic                 i_end_of_source,
    input  logic [7:0]           i_quote_char,
    input  t_state               i_state,
    output t_state               o_state,
    output t_res [MAX_RES-1:0]   o_res,
    output logic [2:0]           o_cnt
);

    t_state             ns;
    t_res [MAX_RES-1:0] res;
    logic [2:0]         cnt;
    logic               do_plain;
    logic [7:0]         oct_next;
    logic [1:0]         left_next;

    always_comb begin
        ns        = i_state;
        res       = '0;
        cnt       = 3'd0;
        do_plain  = 1'b0;
        oct_next  = {i_state.oct_val[4:0], i_ch[2:0]};
        left_next = i_state.oct_left - 2'd1;

        if (i_end_of_source) begin
            case (i_state.mode)
                M_ESC: begin
                    res[cnt[1:0]] = {C_BSLASH, K_BYTE};
                    cnt = cnt + 3'd1;
                end
                M_OCT: begin
                    res[cnt[1:0]] = {i_state.oct_val, K_BYTE};
                    cnt = cnt + 3'd1;
                end
                M_HEX1: begin
                    res[cnt[1:0]] = {C_BSLASH, K_BYTE};
                    cnt = cnt + 3'd1;
                    res[cnt[1:0]] = {C_LC_X, K_BYTE};
                    cnt = cnt + 3'd1;
                end
                M_HEX2: begin
                    res[cnt[1:0]] = {C_BSLASH, K_BYTE};
                    cnt = cnt + 3'd1;
                    res[cnt[1:0]] = {C_LC_X, K_BYTE};
                    cnt = cnt + 3'd1;
                    res[cnt[1:0]] = {i_state.hex_held, K_BYTE};
                    cnt = cnt + 3'd1;
                end
                default: begin
                end
            endcase
            res[cnt[1:0]] = {8'd0, K_UNTERM};
            cnt = cnt + 3'd1;
            ns = C_STATE_CLEAR;
        end else begin
            case (i_state.mode)
                M_ESC: begin
                    ns.mode = M_PLAIN;
                    if (i_ch == C_DQUOTE || i_ch == C_SQUOTE || i_ch == C_BSLASH) begin
                        res[cnt[1:0]] = {i_ch, K_BYTE};
                        cnt = cnt + 3'd1;
                    end else if (i_ch == C_LC_N) begin
                        res[cnt[1:0]] = {C_LF, K_BYTE};
                        cnt = cnt + 3'd1;
                    end else if (i_ch == C_LC_R) begin
                        res[cnt[1:0]] = {C_CR, K_BYTE};
                        cnt = cnt + 3'd1;
                    end else if (i_ch == C_LC_T) begin
                        res[cnt[1:0]] = {C_TAB, K_BYTE};
                        cnt = cnt + 3'd1;
                    end else if (i_ch inside {[C_DIG0:C_DIG7]}) begin
                        ns.mode     = M_OCT;
                        ns.oct_val  = {5'd0, i_ch[2:0]};
                        ns.oct_left = (i_ch inside {[C_DIG0:C_DIG3]}) ? 2'd2 : 2'd1;
                    end else if (i_ch == C_LC_X) begin
                        ns.mode = M_HEX1;
                    end else begin
                        res[cnt[1:0]] = {C_BSLASH, K_BYTE};
                        cnt = cnt + 3'd1;
                    end
                end
                M_OCT: begin
                    if ((i_ch inside {[C_DIG0:C_DIG7]}) && i_state.oct_left != 2'd0) begin
                        if (left_next == 2'd0) begin
                            res[cnt[1:0]] = {oct_next, K_BYTE};
                            cnt = cnt + 3'd1;
                            ns = C_STATE_CLEAR;
                        end else begin
                            ns.oct_val  = oct_next;
                            ns.oct_left = left_next;
                        end
                    end else begin
                        res[cnt[1:0]] = {i_state.oct_val, K_BYTE};
                        cnt = cnt + 3'd1;
                        ns = C_STATE_CLEAR;
                        do_plain = 1'b1;
                    end
                end
                M_HEX1: begin
                    if (hex_ok(i_ch)) begin
                        ns.hex_held = i_ch;
                        ns.mode     = M_HEX2;
                    end else begin
                        res[cnt[1:0]] = {C_BSLASH, K_BYTE};
                        cnt = cnt + 3'd1;
                        res[cnt[1:0]] = {C_LC_X, K_BYTE};
                        cnt = cnt + 3'd1;
                        ns = C_STATE_CLEAR;
                        do_plain = 1'b1;
                    end
                end
                M_HEX2: begin
                    if (hex_ok(i_ch) && hex_ok(i_state.hex_held)) begin
                        res[cnt[1:0]] = {hex_val(i_state.hex_held), hex_val(i_ch), K_BYTE};
                        cnt = cnt + 3'd1;
                        ns = C_STATE_CLEAR;
                    end else begin
                        res[cnt[1:0]] = {C_BSLASH, K_BYTE};
                        cnt = cnt + 3'd1;
                        res[cnt[1:0]] = {C_LC_X, K_BYTE};
                        cnt = cnt + 3'd1;
                        res[cnt[1:0]] = {i_state.hex_held, K_BYTE};
                        cnt = cnt + 3'd1;
                        ns = C_STATE_CLEAR;
                        do_plain = 1'b1;
                    end
                end
                default: begin
                    ns.mode  = M_PLAIN;
                    do_plain = 1'b1;
                end
            endcase

            // plain-mode byte or pushed-back byte goes through plain handling
            if (do_plain) begin
                if (i_ch == i_quote_char) begin
                    res[cnt[1:0]] = {8'd0, K_CLOSED};
                    cnt = cnt + 3'd1;
                    ns = C_STATE_CLEAR;
                end else if (i_ch == C_BSLASH) begin
                    ns.mode = M_ESC;
                end else begin
                    res[cnt[1:0]] = {i_ch, K_BYTE};
                    cnt = cnt + 3'd1;
                end
            end
        end
    end

    assign o_state = ns;
    assign o_res   = res;
    assign o_cnt   = cnt;

endmodule

### hw/rtl/sled_checker.sv
// Port-level checker for the string literal escape decoder, with its bind
`include "string_literal_escape_decoder_top_assert.svh"

module sled_checker
    import sled_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic [1:0] o_kind,
    input logic       o_last
);

    `SLED_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)
    `SLED_ASSERT(a_status_final, i_clk, i_rst_n,
        o_valid && o_kind != K_BYTE |-> o_last && o_out_byte == 8'd0 &&
        (o_kind == K_CLOSED || o_kind == K_UNTERM))
    `SLED_ASSERT(a_more_follow, i_clk, i_rst_n,
        o_valid && !o_last && i_ready |=> o_valid)
    `SLED_ASSERT(a_no_take_mid, i_clk, i_rst_n, o_valid && !o_last |-> !o_ready)
    `SLED_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_kind))

endmodule

bind string_literal_escape_decoder_top sled_checker u_sled_checker (.*);
